@@ hw/rtl/uartrx_pkg.sv @@
// Package for the UART receiver with receive ring buffer.
// Holds payload structs, buffer sizing, command and register codes, and the read FSM type.
// No dependencies.
`timescale 1ns / 1ps

package uartrx_pkg;

	localparam int BUF_DEPTH = 64;
	localparam int PTR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int LEN_W = 7;
	localparam int CNT_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
	localparam logic [LEN_W-1:0] READ_MAX = LEN_W'(64);

	localparam int TIMER_W = 20;
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
	localparam int TPB_W = 16;
	localparam logic [3:0] DATA_BITS = 4'd8;

	localparam int ADDR_W = 3;
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam logic REG_TICKS = 1'b0;
	localparam logic REG_ENABLE = 1'b1;

	typedef struct packed {
		logic             command;
		logic             rx_line;
		logic [LEN_W-1:0] read_length;
	} req_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             byte_valid;
		logic             last_byte;
		logic [LEN_W-1:0] byte_count;
		logic             overflow_seen;
	} rsp_t;

	// Byte finished by the sampler on this tick.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} rx_byte_t;

	typedef enum logic [1:0] {
		RD_IDLE,
		RD_EMPTY,
		RD_DATA
	} rd_state_t;

endpackage

@@ hw/rtl/uart_receiver_ring_buffer.sv @@
// Top level of the UART receiver: APB registers, receive ring buffer memory and read sequencer.
// Depends on uartrx_pkg and uartrx_sampler.
//
//  channel | direction | handshake            | beat
//  req     | in        | req_valid/req_ready  | tick with line level, or read request
//  rsp     | out       | rsp_valid/rsp_ready  | one byte of a read, or the empty answer
//  apb     | in        | psel/penable/pready  | register write or read
//
// A tick beat is absorbed once accepted. A read beat returns one result per byte; the buffer
// memory read is registered, so the first byte passes through rd_data_q and then the output
// register after the read is accepted, and the following ones come at one per cycle while
// rsp_ready stays high. A read occupies the request side until its last byte is loaded into
// the output register. Reset empties the buffer pointers at once; no clearing pass is needed.
`timescale 1ns / 1ps

module uart_receiver_ring_buffer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  uartrx_pkg::req_t             req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output uartrx_pkg::rsp_t             rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [uartrx_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import uartrx_pkg::*;

	logic [TPB_W-1:0] tpb_q;
	logic             enable_q;
	logic             cfg_we;

	logic             req_fire, tick, read_fire;
	rx_byte_t         rx_byte;

	logic [7:0]       mem_q [BUF_DEPTH];
	logic [7:0]       rd_data_q;
	logic [PTR_W-1:0] wp_q, rp_q, rp_next, wp_next, rd_addr, avail;
	logic             full, mem_we, mem_re;
	logic             ovf_q;

	rd_state_t        state_q, state_d;
	logic [LEN_W-1:0] rem_q, rem_d, cnt_q, cnt_d;
	logic             ovf_seen_q, ovf_seen_d;
	logic [LEN_W-1:0] want, count;
	logic [CNT_W-1:0] want_x, avail_x;
	logic             out_free, out_load;
	rsp_t             out_d, out_q;
	logic             out_valid_q;
	logic             rp_adv;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q <= TPB_W'(1);
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_TICKS:  tpb_q <= pwdata[TPB_W-1:0];
				REG_ENABLE: enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_TICKS:  prdata = 32'(tpb_q);
			REG_ENABLE: prdata = 32'(enable_q);
			default: ;
		endcase
	end

	// Request side.
	assign req_ready = (state_q == RD_IDLE);
	assign req_fire = req_valid && req_ready;
	assign tick = req_fire && (req.command == CMD_TICK) && enable_q;
	assign read_fire = req_fire && (req.command == CMD_READ);

	uartrx_sampler u_sampler (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (tick),
		.level         (req.rx_line),
		.ticks_per_bit (tpb_q),
		.rx_byte       (rx_byte)
	);

	// Ring buffer: one slot stays free so that full and empty differ.
	assign wp_next = wp_q + 1'b1;
	assign rp_next = rp_q + 1'b1;
	assign full = (wp_next == rp_q);
	assign mem_we = rx_byte.valid && !full;
	assign avail = wp_q - rp_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wp_q] <= rx_byte.data;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (mem_we) begin
				wp_q <= wp_next;
			end
			if (rp_adv) begin
				rp_q <= rp_next;
			end
			// A tick and a read never share a cycle, so set and clear cannot collide.
			if (rx_byte.valid && full) begin
				ovf_q <= 1'b1;
			end else if (read_fire) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// Read sequencer.
	assign want = (req.read_length > READ_MAX) ? READ_MAX : req.read_length;
	assign want_x = CNT_W'(want);
	assign avail_x = CNT_W'(avail);
	assign count = (enable_q && avail != '0)
		? ((want_x < avail_x) ? want : LEN_W'(avail_x)) : '0;
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		rem_d = rem_q;
		cnt_d = cnt_q;
		ovf_seen_d = ovf_seen_q;
		mem_re = 1'b0;
		rd_addr = rp_q;
		out_load = 1'b0;
		out_d = out_q;
		rp_adv = 1'b0;
		unique case (state_q)
			RD_IDLE: begin
				if (read_fire) begin
					ovf_seen_d = ovf_q;
					cnt_d = count;
					rem_d = count;
					if (count == '0) begin
						state_d = RD_EMPTY;
					end else begin
						mem_re = 1'b1;
						state_d = RD_DATA;
					end
				end
			end
			RD_EMPTY: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d.data_byte = '0;
					out_d.byte_valid = 1'b0;
					out_d.last_byte = 1'b1;
					out_d.byte_count = '0;
					out_d.overflow_seen = ovf_seen_q;
					state_d = RD_IDLE;
				end
			end
			RD_DATA: begin
				// rd_data_q holds the byte at rp_q until it is loaded.
				if (out_free) begin
					out_load = 1'b1;
					out_d.data_byte = rd_data_q;
					out_d.byte_valid = 1'b1;
					out_d.last_byte = (rem_q == LEN_W'(1));
					out_d.byte_count = cnt_q;
					out_d.overflow_seen = ovf_seen_q;
					rp_adv = 1'b1;
					rem_d = rem_q - 1'b1;
					if (rem_q == LEN_W'(1)) begin
						state_d = RD_IDLE;
					end else begin
						mem_re = 1'b1;
						rd_addr = rp_next;
					end
				end
			end
			default: state_d = RD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RD_IDLE;
			rem_q <= '0;
			cnt_q <= '0;
			ovf_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rem_q <= rem_d;
			cnt_q <= cnt_d;
			ovf_seen_q <= ovf_seen_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule

@@ hw/rtl/uartrx_sampler.sv @@
// Bit timer and frame sampler of the UART receiver: start detection, drift-corrected
// sampling of eight data bits and the stop-time handoff of the byte. Depends on uartrx_pkg.
`timescale 1ns / 1ps

module uartrx_sampler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tick,
	input  logic                        level,
	input  logic [uartrx_pkg::TPB_W-1:0] ticks_per_bit,
	output uartrx_pkg::rx_byte_t        rx_byte
);
	import uartrx_pkg::*;

	logic [TIMER_W-1:0] timer_q, timer_d, timer_inc;
	logic [TIMER_W-1:0] next_q, next_d;
	logic [3:0]         pos_q, pos_d;
	logic [7:0]         shift_q, shift_d;
	logic               prev_q, prev_d;
	logic               idle_q, idle_d;
	logic [TIMER_W+1:0] target_sum;
	logic [TIMER_W+1:0] target_diff;

	always_comb begin
		timer_d = timer_q;
		next_d = next_q;
		pos_d = pos_q;
		shift_d = shift_q;
		prev_d = prev_q;
		idle_d = idle_q;
		rx_byte = '0;
		timer_inc = (timer_q != TIMER_MAX) ? timer_q + 1'b1 : timer_q;
		// Next sample point, pulled back by how late this sample was taken.
		target_sum = {1'b0, next_q, 1'b0} + (TIMER_W+2)'(ticks_per_bit);
		target_diff = target_sum - (TIMER_W+2)'(timer_inc);
		if (tick) begin
			prev_d = level;
			if (!level && prev_q && idle_q) begin
				timer_d = '0;
				next_d = TIMER_W'(ticks_per_bit) + TIMER_W'(ticks_per_bit[TPB_W-1:1]);
				shift_d = '0;
				idle_d = 1'b0;
			end else begin
				timer_d = timer_inc;
				if (!idle_q && timer_inc >= next_q) begin
					if (pos_q < DATA_BITS) begin
						shift_d[pos_q[2:0]] = level;
						pos_d = pos_q + 1'b1;
					end else begin
						pos_d = '0;
						idle_d = 1'b1;
						rx_byte.valid = 1'b1;
						rx_byte.data = shift_q;
					end
					if (target_sum < (TIMER_W+2)'(timer_inc)) begin
						next_d = '0;
					end else if (target_diff > (TIMER_W+2)'(TIMER_MAX)) begin
						next_d = TIMER_MAX;
					end else begin
						next_d = target_diff[TIMER_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			next_q <= '0;
			pos_q <= '0;
			shift_q <= '0;
			prev_q <= 1'b0;
			idle_q <= 1'b1;
		end else begin
			timer_q <= timer_d;
			next_q <= next_d;
			pos_q <= pos_d;
			shift_q <= shift_d;
			prev_q <= prev_d;
			idle_q <= idle_d;
		end
	end

endmodule
